// File: sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants and types for the line pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  // Default coordinate width; the top level hands it down as a parameter.
  localparam int unsigned CoordBitsDef = 16;

  // Screen size registers.
  localparam int unsigned ScrBits = 15;
  localparam logic [ScrBits-1:0] ScreenWidthRst  = 15'd1920;
  localparam logic [ScrBits-1:0] ScreenHeightRst = 15'd1080;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  // Item kinds on the request channel.
  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_STEP    = 1'b1
  } item_kind_e;

endpackage

`default_nettype wire

// File: sv/lps_if.sv
// ----------------------------------------------------------------------------
// lps_req_if / lps_pix_if
// Valid/ready channels for request items and pixel items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_req_if #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lps_pix_if #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         on_screen;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, on_screen, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, on_screen, last, output ready);
endinterface

`default_nettype wire

// File: sv/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Line rasterizer: segment items load endpoints, step items emit pixels.
// ----------------------------------------------------------------------------
// Path: a step item passes through the input register, then the result
// register, before its pixel is valid on the output channel.
// Throughput: one item per cycle unless the result register is full; the
// error step's add, compare and subtract sit between the two registers.
// Reset: asynchronous, active low; no segment is loaded, the screen is
// 1920 by 1080, and both channel registers are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_stepper #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lps_req_if.sink                           req_i,
  lps_pix_if.source                         pix_o,
  input  wire logic                         cfg_we_i,
  input  wire lps_pkg::cfg_reg_e            cfg_idx_i,
  input  wire logic [lps_pkg::ScrBits-1:0]  cfg_data_i
);
  import lps_pkg::*;

  // Screen size as written through the configuration port.
  logic [ScrBits-1:0] width, height;

  // Held request item.
  logic                         in_valid;
  logic                         in_kind;
  logic signed [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;

  // Result of the core, and flow control between the stages.
  logic                         out_free;
  logic                         fire;
  logic                         res_valid;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic                         res_on, res_last;

  lps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .width_o    (width),
    .height_o   (height)
  );

  // The input register accepts a new item whenever its current one moves on,
  // so the request channel never waits on the block being idle.
  lps_in_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .out_free_i (out_free),
    .valid_o    (in_valid),
    .kind_o     (in_kind),
    .start_x_o  (in_sx),
    .start_y_o  (in_sy),
    .end_x_o    (in_ex),
    .end_y_o    (in_ey)
  );

  // An item is consumed by the core exactly when the result register has
  // room, whether or not that item yields a pixel.
  assign fire = in_valid && out_free;

  // The core holds the line state, loads it on a segment item and does one Bresenham step per step item.
  lps_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .kind_i      (in_kind),
    .start_x_i   (in_sx),
    .start_y_i   (in_sy),
    .end_x_i     (in_ex),
    .end_y_i     (in_ey),
    .width_i     (width),
    .height_i    (height),
    .res_valid_o (res_valid),
    .pixel_x_o   (res_x),
    .pixel_y_o   (res_y),
    .on_screen_o (res_on),
    .last_o      (res_last)
  );

  // The result register separates the output handshake from the core, so a
  // waiting pixel holds back new items only once the input register is full
  // as well.
  lps_out_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .pixel_x_i   (res_x),
    .pixel_y_i   (res_y),
    .on_screen_i (res_on),
    .last_i      (res_last),
    .out_free_o  (out_free),
    .pix_o       (pix_o)
  );

endmodule

`default_nettype wire

// File: sv/lps_cfg_regs.sv
// ----------------------------------------------------------------------------
// lps_cfg_regs
// Screen width and height registers behind a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire lps_pkg::cfg_reg_e              cfg_idx_i,
  input  wire logic [lps_pkg::ScrBits-1:0]    cfg_data_i,
  output logic      [lps_pkg::ScrBits-1:0]    width_o,
  output logic      [lps_pkg::ScrBits-1:0]    height_o
);
  import lps_pkg::*;

  logic [ScrBits-1:0] width_q, width_d;
  logic [ScrBits-1:0] height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_d  = cfg_data_i;
        CFG_SCREEN_HEIGHT: height_d = cfg_data_i;
        default: begin
          width_d  = width_q;
          height_d = height_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

// File: sv/lps_in_stage.sv
// ----------------------------------------------------------------------------
// lps_in_stage
// Input register for request items; frees itself when the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_in_stage #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lps_req_if.sink                            req_i,
  input  wire logic                          out_free_i,
  output logic                               valid_o,
  output logic                               kind_o,
  output logic signed [COORD_BITS-1:0]       start_x_o,
  output logic signed [COORD_BITS-1:0]       start_y_o,
  output logic signed [COORD_BITS-1:0]       end_x_o,
  output logic signed [COORD_BITS-1:0]       end_y_o
);
  import lps_pkg::*;

  logic                         valid_q, valid_d;
  logic                         kind_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                         take;

  // The held item leaves whenever the result register can take its outcome.
  assign req_i.ready = !valid_q || out_free_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_free_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= req_i.kind;
      sx_q   <= req_i.start_x;
      sy_q   <= req_i.start_y;
      ex_q   <= req_i.end_x;
      ey_q   <= req_i.end_y;
    end
  end

  assign valid_o   = valid_q;
  assign kind_o    = kind_q;
  assign start_x_o = sx_q;
  assign start_y_o = sy_q;
  assign end_x_o   = ex_q;
  assign end_y_o   = ey_q;

endmodule

`default_nettype wire

// File: sv/lps_core.sv
// ----------------------------------------------------------------------------
// lps_core
// Line state and one Bresenham step: segment load or next pixel per item.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_core #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic                          kind_i,
  input  wire logic signed [COORD_BITS-1:0]  start_x_i,
  input  wire logic signed [COORD_BITS-1:0]  start_y_i,
  input  wire logic signed [COORD_BITS-1:0]  end_x_i,
  input  wire logic signed [COORD_BITS-1:0]  end_y_i,
  input  wire logic [lps_pkg::ScrBits-1:0]   width_i,
  input  wire logic [lps_pkg::ScrBits-1:0]   height_i,
  output logic                               res_valid_o,
  output logic signed [COORD_BITS-1:0]       pixel_x_o,
  output logic signed [COORD_BITS-1:0]       pixel_y_o,
  output logic                               on_screen_o,
  output logic                               last_o
);
  import lps_pkg::*;

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned ErrBits  = COORD_BITS + 3;
  localparam int unsigned CmpBits  = (COORD_BITS > ScrBits) ? COORD_BITS : ScrBits;

  // Line state.
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0] major_q, major_d, minor_q, minor_d;
  logic signed [ErrBits-1:0] err_q, err_d;
  logic dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic x_major_q, x_major_d, active_q, active_d;

  // Segment load.
  logic signed [DiffBits-1:0] dx, dy;
  logic [DiffBits-1:0]        adx_w, ady_w;
  logic [COORD_BITS-1:0]      ax, ay;
  logic                       ld_x_major;

  // Pixel step.
  logic signed [ErrBits-1:0] err_sum, twice_minor, twice_major, major_ext;
  logic                      step_minor;
  logic [COORD_BITS-1:0]     x_mv, y_mv, nx, ny;
  logic                      fin;
  logic                      x_ok, y_ok;

  assign dx    = DiffBits'(end_x_i) - DiffBits'(start_x_i);
  assign dy    = DiffBits'(end_y_i) - DiffBits'(start_y_i);
  assign adx_w = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
  assign ady_w = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
  // Extents never exceed 2^COORD_BITS - 1.
  assign ax    = adx_w[COORD_BITS-1:0];
  assign ay    = ady_w[COORD_BITS-1:0];
  assign ld_x_major = ax > ay;

  // Scaled error: gain twice the minor extent, and step the minor axis once
  // the sum reaches the major extent.
  assign twice_minor = ErrBits'({minor_q, 1'b0});
  assign twice_major = ErrBits'({major_q, 1'b0});
  assign major_ext   = ErrBits'(major_q);
  assign err_sum     = err_q + twice_minor;
  assign step_minor  = err_sum >= major_ext;

  assign x_mv = dir_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign y_mv = dir_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
  assign nx   = (x_major_q || step_minor) ? x_mv : cur_x_q;
  assign ny   = (!x_major_q || step_minor) ? y_mv : cur_y_q;
  assign fin  = x_major_q ? (nx == tgt_x_q) : (ny == tgt_y_q);

  // Clip test on the pixel being produced.
  assign x_ok = !cur_x_q[COORD_BITS-1] && (CmpBits'(cur_x_q) < CmpBits'(width_i));
  assign y_ok = !cur_y_q[COORD_BITS-1] && (CmpBits'(cur_y_q) < CmpBits'(height_i));

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    major_d     = major_q;
    minor_d     = minor_q;
    err_d       = err_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    x_major_d   = x_major_q;
    active_d    = active_q;
    if (fire_i) begin
      if (kind_i == KIND_SEGMENT) begin
        cur_x_d     = start_x_i;
        cur_y_d     = start_y_i;
        tgt_x_d     = end_x_i;
        tgt_y_d     = end_y_i;
        dir_x_neg_d = dx[DiffBits-1];
        dir_y_neg_d = dy[DiffBits-1];
        x_major_d   = ld_x_major;
        major_d     = ld_x_major ? ax : ay;
        minor_d     = ld_x_major ? ay : ax;
        err_d       = '0;
        active_d    = (ld_x_major ? ax : ay) != '0;
      end else if (active_q) begin
        cur_x_d  = nx;
        cur_y_d  = ny;
        err_d    = step_minor ? err_sum - twice_major : err_sum;
        active_d = !fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      err_q       <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      x_major_q   <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      err_q       <= err_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      x_major_q   <= x_major_d;
      active_q    <= active_d;
    end
  end

  assign res_valid_o = fire_i && (kind_i == KIND_STEP) && active_q;
  assign pixel_x_o   = cur_x_q;
  assign pixel_y_o   = cur_y_q;
  assign on_screen_o = x_ok && y_ok;
  assign last_o      = fin;

endmodule

`default_nettype wire

// File: sv/lps_out_stage.sv
// ----------------------------------------------------------------------------
// lps_out_stage
// Result register for pixel items on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_out_stage #(
  parameter int unsigned COORD_BITS = lps_pkg::CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          res_valid_i,
  input  wire logic signed [COORD_BITS-1:0]  pixel_x_i,
  input  wire logic signed [COORD_BITS-1:0]  pixel_y_i,
  input  wire logic                          on_screen_i,
  input  wire logic                          last_i,
  output logic                               out_free_o,
  lps_pix_if.source                          pix_o
);
  import lps_pkg::*;

  logic                         valid_q, valid_d;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic                         on_q, last_q;

  // The register can take a new result when empty or being drained.
  assign out_free_o = !valid_q || pix_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (pix_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      on_q   <= on_screen_i;
      last_q <= last_i;
    end
  end

  assign pix_o.valid     = valid_q;
  assign pix_o.pixel_x   = px_q;
  assign pix_o.pixel_y   = py_q;
  assign pix_o.on_screen = on_q;
  assign pix_o.last      = last_q;

endmodule

`default_nettype wire
